// File: design/dmrd_pkg.sv
// Shared types, codes and helpers for the dual motor ramp drive.
`default_nettype none
package dmrd_pkg;

  typedef logic signed [7:0]  pct_t;
  typedef logic signed [17:0] level_t;

  typedef enum logic [3:0] {
    MODE_TICK    = 4'd0,
    MODE_SET_L   = 4'd1,
    MODE_SET_R   = 4'd2,
    MODE_INSTANT = 4'd3,
    MODE_BURST   = 4'd4,
    MODE_STOP    = 4'd5,
    MODE_BRAKE   = 4'd6,
    MODE_CLIFF   = 4'd7,
    MODE_ENABLE  = 4'd8
  } mode_e;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_BRAKE,
    ACT_WRITE
  } act_e;

  typedef struct packed {
    logic burst;
    logic cliff;
    logic enabled;
  } status_t;

  localparam logic [1:0]  CFG_RAMP_RATE = 2'd0;
  localparam logic [1:0]  CFG_MIN_PWM   = 2'd1;
  localparam logic [1:0]  CFG_MAX_PWM   = 2'd2;

  localparam logic [15:0] RAMP_RATE_RST = 16'd200;
  localparam logic [7:0]  MIN_PWM_RST   = 8'd0;
  localparam logic [7:0]  MAX_PWM_RST   = 8'd255;
  localparam logic [7:0]  DUTY_BRAKE    = 8'd255;

  localparam int unsigned SPEED_MAX   = 100;
  localparam int unsigned LEVEL_SCALE = 1000;
  localparam int unsigned LEVEL_HALF  = LEVEL_SCALE / 2;

  // x / 1000 for x below 2^17: exact with this reciprocal
  localparam int unsigned RND_SHIFT = 27;
  localparam logic [34:0] RND_RECIP = 35'((64'd1 << RND_SHIFT) / LEVEL_SCALE + 1);

  // x / 99 for x up to 99 * 255: exact with this reciprocal
  localparam int unsigned MAP_SHIFT = 16;
  localparam logic [24:0] MAP_RECIP = 25'((64'd1 << MAP_SHIFT) / (SPEED_MAX - 1) + 1);

  function automatic pct_t clamp_pct(input pct_t s);
    if (s > pct_t'(SPEED_MAX)) begin
      return pct_t'(SPEED_MAX);
    end
    if (s < -8'sd100) begin
      return -8'sd100;
    end
    return s;
  endfunction

  function automatic pct_t safe_pct(input pct_t s, input logic enabled, input logic cliff);
    if (!enabled) begin
      return '0;
    end
    if (cliff && (s > 8'sd0)) begin
      return '0;
    end
    return s;
  endfunction

  function automatic level_t pct_to_level(input pct_t s);
    logic signed [18:0] wide;
    wide = 19'(s) * 19'sd1000;
    return level_t'(wide);
  endfunction

  function automatic level_t move_level(input level_t cur, input pct_t goal,
                                        input logic [25:0] step);
    logic signed [18:0] c;
    logic signed [18:0] t;
    logic [18:0]        gap;
    level_t             res;
    c    = 19'(cur);
    t    = 19'(pct_to_level(goal));
    gap  = '0;
    res  = cur;
    if (c < t) begin
      gap = 19'(t - c);
      res = (26'(gap) <= step) ? level_t'(t) : level_t'(c + $signed(step[18:0]));
    end else if (c > t) begin
      gap = 19'(c - t);
      res = (26'(gap) <= step) ? level_t'(t) : level_t'(c - $signed(step[18:0]));
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// File: design/dual_motor_ramp_drive_unit.sv
// Dual H-bridge motor drive with slew-rate limited speed and PWM duty map.
//
// One result beat per command beat, one beat per cycle sustained. An
// accepted command reaches output valid through four register stages
// behind the input register: the command stage, where the goal and level
// registers of both motors are updated in the cycle a command leaves the
// input register, then rounding and the two duty map multiplies in three
// further stages, and the duty registers are written as the result enters
// the output register. The whole pipeline advances together and holds
// while the output beat is stalled.
// Config writes take effect at once and are meant for an idle block.
`default_nettype none
module dual_motor_ramp_drive_unit
  import dmrd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,

  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [3:0]  mode_i,
  input  wire logic [7:0]  left_speed_i,
  input  wire logic [7:0]  right_speed_i,
  input  wire logic [15:0] duration_ms_i,
  input  wire logic [9:0]  elapsed_ms_i,
  input  wire logic        flag_i,

  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       left_fwd_duty_o,
  output logic [7:0]       left_rev_duty_o,
  output logic [7:0]       right_fwd_duty_o,
  output logic [7:0]       right_rev_duty_o,
  output logic [7:0]       left_speed_now_o,
  output logic [7:0]       right_speed_now_o,
  output logic             burst_running_o,
  output logic             cliff_state_o,
  output logic             enabled_state_o
);

  logic [15:0] rate_q;
  logic [7:0]  min_q;
  logic [7:0]  max_q;

  logic        adv;
  logic        s1_valid_q, b_valid_q, c_valid_q, d_valid_q, out_valid_q;

  logic [3:0]  s1_mode_q;
  pct_t        s1_speed_q [2];
  logic [15:0] s1_dur_q;
  logic [9:0]  s1_el_q;
  logic        s1_flag_q;

  pct_t        goal_q [2];
  pct_t        goal_d [2];
  level_t      level_q [2];
  level_t      level_d [2];
  logic        burst_q, burst_d;
  logic [15:0] burst_ms_q, burst_ms_d;
  logic        cliff_q, cliff_d;
  logic        en_q, en_d;
  act_e        act_a;

  act_e        b_act_q;
  level_t      b_level_q [2];
  status_t     b_stat_q;
  pct_t        b_speed [2];

  act_e        c_act_q;
  pct_t        c_speed_q [2];
  status_t     c_stat_q;
  logic [14:0] c_prod [2];

  act_e        d_act_q;
  pct_t        d_speed_q [2];
  logic [14:0] d_prod_q [2];
  status_t     d_stat_q;
  logic [7:0]  pwm [2];

  logic [7:0]  duty_q [4];
  logic [7:0]  duty_d [4];
  pct_t        out_speed_q [2];
  status_t     out_stat_q;

  logic [7:0]  hi_pwm;
  logic [7:0]  span;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  assign hi_pwm = (max_q < min_q) ? min_q : max_q;
  assign span   = hi_pwm - min_q;

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RAMP_RATE_RST;
      min_q  <= MIN_PWM_RST;
      max_q  <= MAX_PWM_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RAMP_RATE: rate_q <= cfg_wdata_i;
        CFG_MIN_PWM:   min_q  <= cfg_wdata_i[7:0];
        CFG_MAX_PWM:   max_q  <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      d_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= in_valid_i;
      b_valid_q   <= s1_valid_q;
      c_valid_q   <= b_valid_q;
      d_valid_q   <= c_valid_q;
      out_valid_q <= d_valid_q;
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      s1_mode_q     <= mode_i;
      s1_speed_q[0] <= clamp_pct(left_speed_i);
      s1_speed_q[1] <= clamp_pct(right_speed_i);
      s1_dur_q      <= duration_ms_i;
      s1_el_q       <= elapsed_ms_i;
      s1_flag_q     <= flag_i;
    end
  end

  // command stage
  always_comb begin
    logic        brake;
    logic [25:0] step;
    goal_d     = goal_q;
    level_d    = level_q;
    burst_d    = burst_q;
    burst_ms_d = burst_ms_q;
    cliff_d    = cliff_q;
    en_d       = en_q;
    act_a      = ACT_NONE;
    brake      = 1'b0;
    step       = 26'(rate_q) * 26'(s1_el_q);
    unique case (s1_mode_q)
      MODE_TICK: begin
        if (burst_q) begin
          if (16'(s1_el_q) >= burst_ms_q) begin
            goal_d[0]  = '0;
            goal_d[1]  = '0;
            burst_d    = 1'b0;
            burst_ms_d = '0;
          end else begin
            burst_ms_d = burst_ms_q - 16'(s1_el_q);
          end
        end
        for (int s = 0; s < 2; s++) begin
          level_d[s] = move_level(level_q[s], goal_d[s], step);
        end
        act_a = ACT_WRITE;
      end
      MODE_SET_L: goal_d[0] = safe_pct(s1_speed_q[0], en_q, cliff_q);
      MODE_SET_R: goal_d[1] = safe_pct(s1_speed_q[1], en_q, cliff_q);
      MODE_INSTANT: begin
        for (int s = 0; s < 2; s++) begin
          goal_d[s]  = safe_pct(s1_speed_q[s], en_q, cliff_q);
          level_d[s] = pct_to_level(goal_d[s]);
        end
        act_a = ACT_WRITE;
      end
      MODE_BURST: begin
        for (int s = 0; s < 2; s++) begin
          goal_d[s] = safe_pct(s1_speed_q[s], en_q, cliff_q);
        end
        burst_d    = 1'b1;
        burst_ms_d = s1_dur_q;
      end
      MODE_STOP: begin
        goal_d[0]  = '0;
        goal_d[1]  = '0;
        burst_d    = 1'b0;
        burst_ms_d = '0;
      end
      MODE_BRAKE: brake = 1'b1;
      MODE_CLIFF: begin
        brake   = s1_flag_q && !cliff_q;
        cliff_d = s1_flag_q;
      end
      MODE_ENABLE: begin
        brake = !s1_flag_q && en_q;
        en_d  = s1_flag_q;
      end
      default: ;
    endcase
    if (brake) begin
      for (int s = 0; s < 2; s++) begin
        goal_d[s]  = '0;
        level_d[s] = '0;
      end
      burst_d    = 1'b0;
      burst_ms_d = '0;
      act_a      = ACT_BRAKE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_q[0]  <= '0;
      goal_q[1]  <= '0;
      level_q[0] <= '0;
      level_q[1] <= '0;
      burst_q    <= 1'b0;
      burst_ms_q <= '0;
      cliff_q    <= 1'b0;
      en_q       <= 1'b1;
    end else if (adv && s1_valid_q) begin
      goal_q     <= goal_d;
      level_q    <= level_d;
      burst_q    <= burst_d;
      burst_ms_q <= burst_ms_d;
      cliff_q    <= cliff_d;
      en_q       <= en_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_act_q   <= act_a;
      b_level_q <= level_d;
      b_stat_q  <= '{burst: burst_d, cliff: cliff_d, enabled: en_d};
    end
  end

  // round to whole percent, half away from zero
  always_comb begin
    logic        neg;
    logic [16:0] mag;
    logic [34:0] prod;
    logic [7:0]  q;
    for (int s = 0; s < 2; s++) begin
      neg        = b_level_q[s][17];
      mag        = neg ? 17'(-b_level_q[s]) : 17'(b_level_q[s]);
      prod       = 35'(mag + 17'(LEVEL_HALF)) * RND_RECIP;
      q          = {1'b0, prod[RND_SHIFT +: 7]};
      b_speed[s] = neg ? pct_t'(-q) : pct_t'(q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_act_q   <= b_act_q;
      c_speed_q <= b_speed;
      c_stat_q  <= b_stat_q;
    end
  end

  // (|speed| - 1) * span
  always_comb begin
    logic [6:0] mag;
    for (int s = 0; s < 2; s++) begin
      mag       = c_speed_q[s][7] ? 7'(-c_speed_q[s]) : 7'(c_speed_q[s]);
      c_prod[s] = 15'(mag - 7'd1) * 15'(span);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_act_q   <= c_act_q;
      d_speed_q <= c_speed_q;
      d_prod_q  <= c_prod;
      d_stat_q  <= c_stat_q;
    end
  end

  // divide by 99, offset by min duty, steer to the driving side; brake sets all duties
  always_comb begin
    logic [24:0] prod;
    duty_d = duty_q;
    for (int s = 0; s < 2; s++) begin
      prod   = 25'(d_prod_q[s]) * MAP_RECIP;
      pwm[s] = min_q + prod[MAP_SHIFT +: 8];
    end
    unique case (d_act_q)
      ACT_BRAKE: begin
        for (int f = 0; f < 4; f++) begin
          duty_d[f] = DUTY_BRAKE;
        end
      end
      ACT_WRITE: begin
        for (int s = 0; s < 2; s++) begin
          if (d_speed_q[s] == 8'sd0) begin
            duty_d[2*s]   = '0;
            duty_d[2*s+1] = '0;
          end else if (d_speed_q[s][7]) begin
            duty_d[2*s]   = '0;
            duty_d[2*s+1] = pwm[s];
          end else begin
            duty_d[2*s]   = pwm[s];
            duty_d[2*s+1] = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int f = 0; f < 4; f++) begin
        duty_q[f] <= DUTY_BRAKE;
      end
    end else if (adv && d_valid_q) begin
      duty_q <= duty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && d_valid_q) begin
      out_speed_q <= d_speed_q;
      out_stat_q  <= d_stat_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign left_fwd_duty_o   = duty_q[0];
  assign left_rev_duty_o   = duty_q[1];
  assign right_fwd_duty_o  = duty_q[2];
  assign right_rev_duty_o  = duty_q[3];
  assign left_speed_now_o  = out_speed_q[0];
  assign right_speed_now_o = out_speed_q[1];
  assign burst_running_o   = out_stat_q.burst;
  assign cliff_state_o     = out_stat_q.cliff;
  assign enabled_state_o   = out_stat_q.enabled;

endmodule
`default_nettype wire

// File: tb/tb_dual_motor_ramp_drive_unit.sv
// Self-checking testbench for the dual motor ramp drive unit.
module tb_dual_motor_ramp_drive_unit;
  import dmrd_pkg::*;

  localparam int LATENCY = 5;
  localparam int IDLE_LIMIT = 2000;
  localparam logic [1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [7:0] l_fwd;
    logic [7:0] l_rev;
    logic [7:0] r_fwd;
    logic [7:0] r_rev;
    logic [7:0] l_now;
    logic [7:0] r_now;
    logic       burst;
    logic       cliff;
    logic       enabled;
  } drive_report_t;

  typedef struct packed {
    logic [3:0]  mode;
    logic [7:0]  ls;
    logic [7:0]  rs;
    logic [15:0] dur;
    logic [9:0]  el;
    logic        flg;
  } cmd_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [3:0]  mode_i = '0;
  logic [7:0]  left_speed_i = '0;
  logic [7:0]  right_speed_i = '0;
  logic [15:0] duration_ms_i = '0;
  logic [9:0]  elapsed_ms_i = '0;
  logic        flag_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  left_fwd_duty_o;
  logic [7:0]  left_rev_duty_o;
  logic [7:0]  right_fwd_duty_o;
  logic [7:0]  right_rev_duty_o;
  logic [7:0]  left_speed_now_o;
  logic [7:0]  right_speed_now_o;
  logic        burst_running_o;
  logic        cliff_state_o;
  logic        enabled_state_o;

  dual_motor_ramp_drive_unit uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .mode_i(mode_i),
    .left_speed_i(left_speed_i),
    .right_speed_i(right_speed_i),
    .duration_ms_i(duration_ms_i),
    .elapsed_ms_i(elapsed_ms_i),
    .flag_i(flag_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .left_fwd_duty_o(left_fwd_duty_o),
    .left_rev_duty_o(left_rev_duty_o),
    .right_fwd_duty_o(right_fwd_duty_o),
    .right_rev_duty_o(right_rev_duty_o),
    .left_speed_now_o(left_speed_now_o),
    .right_speed_now_o(right_speed_now_o),
    .burst_running_o(burst_running_o),
    .cliff_state_o(cliff_state_o),
    .enabled_state_o(enabled_state_o)
  );

  cmd_t          cmd_q[$];
  drive_report_t report_q[$];
  int            mismatches = 0;
  int            quiet_cycles = 0;
  int            send_gap = 0;
  int            stall_left = 0;
  bit            calm = 1'b0;

  // drive state as predicted
  logic [15:0] rate_cfg;
  logic [7:0]  lo_cfg;
  logic [7:0]  hi_cfg;
  pct_t        goal_l;
  pct_t        goal_r;
  level_t      lvl_l;
  level_t      lvl_r;
  logic        burst_on;
  logic [15:0] burst_left;
  logic        cliff_on;
  logic        enable_on;
  logic [7:0]  duty_r [4];

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic pct_t clamp_speed(input logic [7:0] raw);
    pct_t s;
    s = pct_t'(raw);
    if (s > 8'sd100) return 8'sd100;
    if (s < -8'sd100) return -8'sd100;
    return s;
  endfunction

  function automatic pct_t gate_target(input pct_t s);
    if (!enable_on) return '0;
    if (cliff_on && s > 8'sd0) return '0;
    return s;
  endfunction

  function automatic void stop_all();
    goal_l = '0;
    goal_r = '0;
    burst_on = 1'b0;
    burst_left = '0;
  endfunction

  function automatic void brake_all();
    stop_all();
    lvl_l = '0;
    lvl_r = '0;
    for (int i = 0; i < 4; i++) duty_r[i] = 8'd255;
  endfunction

  function automatic level_t slew(input level_t lv, input pct_t goal, input longint amt);
    longint c;
    longint t;
    c = lv;
    t = longint'(goal) * 1000;
    if (c < t) begin
      c = c + amt;
      if (c > t) c = t;
    end else if (c > t) begin
      c = c - amt;
      if (c < t) c = t;
    end
    return level_t'(c);
  endfunction

  function automatic pct_t round_pct(input level_t lv);
    int v;
    v = lv;
    if (v >= 0) return pct_t'((v + 500) / 1000);
    return pct_t'(-((-v + 500) / 1000));
  endfunction

  function automatic void set_motor(input int side, input pct_t spd);
    int lo;
    int hi;
    int mag;
    int pwm;
    lo = lo_cfg;
    hi = (hi_cfg < lo_cfg) ? int'(lo_cfg) : int'(hi_cfg);
    if (spd == 8'sd0) begin
      duty_r[2*side] = '0;
      duty_r[2*side+1] = '0;
      return;
    end
    mag = (spd > 8'sd0) ? int'(spd) : -int'(spd);
    pwm = lo + ((mag - 1) * (hi - lo)) / 99;
    if (spd > 8'sd0) begin
      duty_r[2*side] = 8'(pwm);
      duty_r[2*side+1] = '0;
    end else begin
      duty_r[2*side] = '0;
      duty_r[2*side+1] = 8'(pwm);
    end
  endfunction

  function automatic void apply_cmd(input cmd_t c);
    pct_t          ls;
    pct_t          rs;
    longint        slew_amt;
    drive_report_t r;
    ls = clamp_speed(c.ls);
    rs = clamp_speed(c.rs);
    case (c.mode)
      MODE_TICK: begin
        if (burst_on) begin
          if (16'(c.el) >= burst_left) stop_all();
          else burst_left = burst_left - 16'(c.el);
        end
        slew_amt = longint'(rate_cfg) * longint'(c.el);
        lvl_l = slew(lvl_l, goal_l, slew_amt);
        lvl_r = slew(lvl_r, goal_r, slew_amt);
        set_motor(0, round_pct(lvl_l));
        set_motor(1, round_pct(lvl_r));
      end
      MODE_SET_L: goal_l = gate_target(ls);
      MODE_SET_R: goal_r = gate_target(rs);
      MODE_INSTANT: begin
        goal_l = gate_target(ls);
        goal_r = gate_target(rs);
        lvl_l = level_t'(int'(goal_l) * 1000);
        lvl_r = level_t'(int'(goal_r) * 1000);
        set_motor(0, goal_l);
        set_motor(1, goal_r);
      end
      MODE_BURST: begin
        goal_l = gate_target(ls);
        goal_r = gate_target(rs);
        burst_on = 1'b1;
        burst_left = c.dur;
      end
      MODE_STOP: stop_all();
      MODE_BRAKE: brake_all();
      MODE_CLIFF: begin
        if (c.flg && !cliff_on) brake_all();
        cliff_on = c.flg;
      end
      MODE_ENABLE: begin
        if (!c.flg && enable_on) brake_all();
        enable_on = c.flg;
      end
      default: ;
    endcase
    r.l_fwd = duty_r[0];
    r.l_rev = duty_r[1];
    r.r_fwd = duty_r[2];
    r.r_rev = duty_r[3];
    r.l_now = round_pct(lvl_l);
    r.r_now = round_pct(lvl_r);
    r.burst = burst_on;
    r.cliff = cliff_on;
    r.enabled = enable_on;
    report_q.push_back(r);
  endfunction

  function automatic void push_cmd(input logic [3:0] m, input logic [7:0] ls,
                                   input logic [7:0] rs, input logic [15:0] dur,
                                   input logic [9:0] el, input logic flg);
    cmd_t c;
    c.mode = m;
    c.ls = ls;
    c.rs = rs;
    c.dur = dur;
    c.el = el;
    c.flg = flg;
    cmd_q.push_back(c);
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int   pick;
    int   sel;
    c.ls = 8'($urandom);
    c.rs = 8'($urandom);
    c.dur = 16'($urandom);
    c.el = 10'($urandom);
    c.flg = 1'($urandom);
    if ($urandom_range(0, 99) < 85) begin
      c.ls = 8'($urandom_range(0, 200) - 100);
      c.rs = 8'($urandom_range(0, 200) - 100);
    end
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      c.mode = MODE_TICK;
      sel = $urandom_range(0, 9);
      if (sel < 6) c.el = 10'($urandom_range(1, 40));
      else if (sel == 8) c.el = '0;
      else if (sel == 9) c.el = 10'($urandom_range(100, 400));
    end else if (pick < 52) begin
      c.mode = MODE_SET_L;
    end else if (pick < 64) begin
      c.mode = MODE_SET_R;
    end else if (pick < 71) begin
      c.mode = MODE_INSTANT;
    end else if (pick < 81) begin
      c.mode = MODE_BURST;
      if ($urandom_range(0, 9) < 7) c.dur = 16'($urandom_range(0, 300));
    end else if (pick < 85) begin
      c.mode = MODE_STOP;
    end else if (pick < 87) begin
      c.mode = MODE_BRAKE;
    end else if (pick < 91) begin
      c.mode = MODE_CLIFF;
      c.flg = ($urandom_range(0, 9) < 3);
    end else if (pick < 97) begin
      c.mode = MODE_ENABLE;
      c.flg = ($urandom_range(0, 9) < 8);
    end else begin
      c.mode = 4'($urandom_range(9, 15));
    end
    return c;
  endfunction

  task automatic set_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_RAMP_RATE: rate_cfg = val;
      CFG_MIN_PWM:   lo_cfg = val[7:0];
      CFG_MAX_PWM:   hi_cfg = val[7:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (cmd_q.size() != 0 || in_valid_i || report_q.size() != 0);
    repeat (LATENCY + 3) @(negedge clk_i);
  endtask

  task automatic run_phase(input logic [15:0] rate, input logic [7:0] lo,
                           input logic [7:0] hi, input int n);
    wait_idle();
    set_reg(CFG_RAMP_RATE, rate);
    set_reg(CFG_MIN_PWM, {8'($urandom), lo});
    set_reg(CFG_MAX_PWM, {8'($urandom), hi});
    set_reg(CFG_SPARE, 16'($urandom));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    repeat (n) cmd_q.push_back(rand_cmd());
  endtask

  // sender
  always @(posedge clk_i) begin : drive_beats
    cmd_t c;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        apply_cmd({mode_i, left_speed_i, right_speed_i, duration_ms_i, elapsed_ms_i,
                   flag_i});
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(1, 17) - 1;
          in_valid_i <= 1'b0;
        end else if (cmd_q.size() != 0) begin
          c = cmd_q.pop_front();
          mode_i <= c.mode;
          left_speed_i <= c.ls;
          right_speed_i <= c.rs;
          duration_ms_i <= c.dur;
          elapsed_ms_i <= c.el;
          flag_i <= c.flg;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i) begin : check_beats
    drive_report_t got;
    drive_report_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = {left_fwd_duty_o, left_rev_duty_o, right_fwd_duty_o, right_rev_duty_o,
               left_speed_now_o, right_speed_now_o, burst_running_o, cliff_state_o,
               enabled_state_o};
        if (report_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %h", got);
        end else begin
          want = report_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch duty exp %0d %0d %0d %0d act %0d %0d %0d %0d",
                       want.l_fwd, want.l_rev, want.r_fwd, want.r_rev,
                       got.l_fwd, got.l_rev, got.r_fwd, got.r_rev);
              $display("  speed exp %0d %0d act %0d %0d  status exp %b%b%b act %b%b%b",
                       $signed(want.l_now), $signed(want.r_now),
                       $signed(got.l_now), $signed(got.r_now),
                       want.burst, want.cliff, want.enabled,
                       got.burst, got.cliff, got.enabled);
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rate_cfg = RAMP_RATE_RST;
    lo_cfg = MIN_PWM_RST;
    hi_cfg = MAX_PWM_RST;
    goal_l = '0;
    goal_r = '0;
    lvl_l = '0;
    lvl_r = '0;
    burst_on = 1'b0;
    burst_left = '0;
    cliff_on = 1'b0;
    enable_on = 1'b1;
    for (int i = 0; i < 4; i++) duty_r[i] = DUTY_BRAKE;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: clamps, full ramps, bursts, safety gating, brake edges
    push_cmd(4'd9, 8'h00, 8'h00, 16'h0000, 10'd0, 1'b0);
    push_cmd(MODE_SET_L, 8'sd127, 8'h00, 16'h0000, 10'd0, 1'b0);
    push_cmd(MODE_SET_R, 8'h00, -8'sd128, 16'h0000, 10'd0, 1'b0);
    push_cmd(MODE_TICK, 8'h00, 8'h00, 16'h0000, 10'd1023, 1'b0);
    push_cmd(MODE_TICK, 8'h00, 8'h00, 16'h0000, 10'd0, 1'b0);
    push_cmd(MODE_INSTANT, 8'sd1, -8'sd1, 16'h0000, 10'd0, 1'b0);
    push_cmd(MODE_INSTANT, 8'sd50, -8'sd50, 16'h0000, 10'd0, 1'b0);
    push_cmd(MODE_BURST, 8'sd100, 8'sd100, 16'd0, 10'd0, 1'b0);
    push_cmd(MODE_TICK, 8'h00, 8'h00, 16'h0000, 10'd0, 1'b0);
    push_cmd(MODE_BURST, 8'sd80, -8'sd80, 16'd10, 10'd0, 1'b0);
    push_cmd(MODE_TICK, 8'h00, 8'h00, 16'h0000, 10'd5, 1'b0);
    push_cmd(MODE_TICK, 8'h00, 8'h00, 16'h0000, 10'd5, 1'b0);
    push_cmd(MODE_STOP, 8'h00, 8'h00, 16'hffff, 10'd0, 1'b0);
    push_cmd(MODE_TICK, 8'h00, 8'h00, 16'h0000, 10'd300, 1'b0);
    push_cmd(MODE_CLIFF, 8'h00, 8'h00, 16'h0000, 10'd0, 1'b1);
    push_cmd(MODE_SET_L, 8'sd50, 8'h00, 16'h0000, 10'd0, 1'b0);
    push_cmd(MODE_INSTANT, 8'sd70, -8'sd70, 16'h0000, 10'd0, 1'b0);
    push_cmd(MODE_CLIFF, 8'h00, 8'h00, 16'h0000, 10'd0, 1'b1);
    push_cmd(MODE_CLIFF, 8'h00, 8'h00, 16'h0000, 10'd0, 1'b0);
    push_cmd(MODE_ENABLE, 8'h00, 8'h00, 16'h0000, 10'd0, 1'b0);
    push_cmd(MODE_SET_R, 8'h00, -8'sd50, 16'h0000, 10'd0, 1'b0);
    push_cmd(MODE_ENABLE, 8'h00, 8'h00, 16'h0000, 10'd0, 1'b0);
    push_cmd(MODE_ENABLE, 8'h00, 8'h00, 16'h0000, 10'd0, 1'b1);
    push_cmd(MODE_INSTANT, 8'sd100, 8'sd100, 16'h0000, 10'd0, 1'b0);
    push_cmd(MODE_BRAKE, 8'hff, 8'hff, 16'hffff, 10'd1023, 1'b1);
    push_cmd(4'd15, 8'h80, 8'h7f, 16'h8000, 10'd512, 1'b1);

    run_phase(16'd1, 8'd0, 8'd255, 150);
    run_phase(16'd65535, 8'd255, 8'd0, 150);
    run_phase(16'd1000, 8'd100, 8'd30, 150);
    run_phase(16'd0, 8'd10, 8'd10, 100);
    run_phase(16'd37, 8'd40, 8'd200, 150);
    wait_idle();
    calm = 1'b1;
    run_phase(16'd200, 8'd0, 8'd255, 350);
    wait_idle();

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
